// File: rtl/lpm_pkg.sv
// Package for the IPv4 longest-prefix-match block: field widths, operation codes
// and the default sizes of the trie node memory.
// Used by ipv4_longest_prefix_match and the testbench; it depends on nothing.
`default_nettype none

package lpm_pkg;

  // Default sizes handed to the top-level parameters.
  localparam int unsigned NodeCountDef   = 4096;
  localparam int unsigned AddressBitsDef = 32;
  localparam int unsigned TagBitsDef     = 16;

  // Fixed widths of the stream fields.
  localparam int unsigned ModeW  = 2;
  localparam int unsigned AddrW  = 32;
  localparam int unsigned PlenW  = 6;
  localparam int unsigned TagW   = 16;
  localparam int unsigned CountW = 20;

  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 40;

  localparam logic [CountW-1:0] CountMax = {CountW{1'b1}};

  typedef enum logic [ModeW-1:0] {
    MODE_INSERT = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_CLEAR  = 2'd2,
    MODE_NONE   = 2'd3
  } mode_e;

endpackage

`default_nettype wire

// File: rtl/lpm_node_mem.sv
// Single-port-write, single-port-read trie node memory with a registered read.
// Holds one packed node word per entry; depends on nothing.
`default_nettype none

module lpm_node_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 41
) (
  input  wire logic                     clk_i,
  input  wire logic                     rd_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic      [WIDTH-1:0]         rd_data_o,
  input  wire logic                     wr_en_i,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  wire logic [WIDTH-1:0]         wr_data_i
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// File: rtl/ipv4_longest_prefix_match.sv
// IPv4 longest-prefix-match table held as a binary trie, with its walk sequencer.
// Depends on lpm_pkg and lpm_node_mem.
//
// Usage: one word on the slave stream is one command, chosen by tuser: insert a
// prefix, look up an address, or clear the table. Every command returns exactly
// one word on the master stream with hit, match tag, table-full flag and the
// prefix count after the command.
// The block handles one command at a time. The sequencer walks the trie one node
// per cycle, bounded by the single read port of the node memory; a command
// visits at most ADDRESS_BITS + 1 nodes, and no new word is taken before the
// result of the last one has been handed over. Clear, the unused code and a
// lookup on an empty table visit no node, so their result can go out in the
// cycle after acceptance.
// New nodes come from a bump pointer and are written whole when handed out, so
// the node memory needs no clearing pass. After reset the table is empty, the
// count is zero and tready is high at once.
// While the result word waits for tready, the block takes no new word.
`default_nettype none

module ipv4_longest_prefix_match #(
  parameter int unsigned NODE_COUNT   = lpm_pkg::NodeCountDef,
  parameter int unsigned ADDRESS_BITS = lpm_pkg::AddressBitsDef,
  parameter int unsigned TAG_BITS     = lpm_pkg::TagBitsDef
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // address [31:0], prefix_len [37:32], info_tag [53:38], zero [55:54]
  input  wire logic [lpm_pkg::InDataW-1:0]  s_axis_tdata_i,
  // mode [1:0]
  input  wire logic [lpm_pkg::ModeW-1:0]    s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  wire logic                         m_axis_tready_i,
  // hit [0], match_tag [16:1], table_full [17], stored_prefixes [37:18],
  // zero [39:38]
  output logic      [lpm_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int unsigned IdxW  = $clog2(NODE_COUNT);
  localparam int unsigned FreeW = IdxW + 1;
  localparam int unsigned RemW  = $clog2(ADDRESS_BITS + 1);
  localparam int unsigned WordW = 2 * IdxW + 1 + TAG_BITS;

  typedef struct packed {
    logic [IdxW-1:0]     left;
    logic [IdxW-1:0]     right;
    logic                has;
    logic [TAG_BITS-1:0] tag;
  } node_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_FRESH,
    ST_OUT
  } state_e;

  state_e                        state_q, state_d;
  logic [ADDRESS_BITS-1:0]       addr_q, addr_d;
  logic [RemW-1:0]               remain_q, remain_d;
  logic [IdxW-1:0]               node_q, node_d;
  logic                          insert_q, insert_d;
  logic [TAG_BITS-1:0]           tag_q, tag_d;
  logic [FreeW-1:0]              next_free_q, next_free_d;
  logic [lpm_pkg::CountW-1:0]    cnt_q, cnt_d;
  logic                          root_clr_q, root_clr_d;
  logic                          found_q, found_d;
  logic [TAG_BITS-1:0]           best_q, best_d;
  logic                          hit_q, hit_d;
  logic [lpm_pkg::TagW-1:0]      mtag_q, mtag_d;
  logic                          full_q, full_d;

  logic              rd_en;
  logic [IdxW-1:0]   rd_addr;
  logic [WordW-1:0]  rd_data;
  logic              wr_en;
  logic [IdxW-1:0]   wr_addr;
  node_t             wr_word;

  node_t                      cur;
  logic                       addr_bit;
  logic [IdxW-1:0]            child;
  logic                       pool_empty;
  logic [IdxW-1:0]            new_idx;
  logic [lpm_pkg::CountW-1:0] cnt_inc;
  logic                       s_hs;
  lpm_pkg::mode_e             mode;
  logic [RemW-1:0]            plen_sat;
  logic [lpm_pkg::PlenW-1:0]  plen_in;

  lpm_node_mem #(
    .DEPTH (NODE_COUNT),
    .WIDTH (WordW)
  ) u_node_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_word)
  );

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = (state_q == ST_OUT);
  assign m_axis_tdata_o  = {2'b00, cnt_q, full_q, mtag_q, hit_q};

  assign s_hs    = s_axis_tvalid_i && s_axis_tready_o;
  assign mode    = lpm_pkg::mode_e'(s_axis_tuser_i);
  assign plen_in = s_axis_tdata_i[37:32];
  assign plen_sat = (plen_in > lpm_pkg::PlenW'(ADDRESS_BITS)) ? RemW'(ADDRESS_BITS)
                                                             : RemW'(plen_in);

  // While the root is marked empty, its stored word is ignored and read as blank.
  assign cur        = (root_clr_q && node_q == '0) ? node_t'('0) : node_t'(rd_data);
  assign addr_bit   = addr_q[ADDRESS_BITS-1];
  assign child      = addr_bit ? cur.right : cur.left;
  assign pool_empty = (next_free_q == FreeW'(NODE_COUNT));
  assign new_idx    = next_free_q[IdxW-1:0];
  assign cnt_inc    = (cnt_q == lpm_pkg::CountMax) ? cnt_q : cnt_q + 1'b1;

  always_comb begin
    state_d     = state_q;
    addr_d      = addr_q;
    remain_d    = remain_q;
    node_d      = node_q;
    insert_d    = insert_q;
    tag_d       = tag_q;
    next_free_d = next_free_q;
    cnt_d       = cnt_q;
    root_clr_d  = root_clr_q;
    found_d     = found_q;
    best_d      = best_q;
    hit_d       = hit_q;
    mtag_d      = mtag_q;
    full_d      = full_q;
    rd_en       = 1'b0;
    rd_addr     = child;
    wr_en       = 1'b0;
    wr_addr     = node_q;
    wr_word     = cur;

    unique case (state_q)
      ST_IDLE: begin
        if (s_hs) begin
          addr_d   = ADDRESS_BITS'(s_axis_tdata_i[31:0]);
          tag_d    = TAG_BITS'(s_axis_tdata_i[53:38]);
          node_d   = '0;
          found_d  = 1'b0;
          best_d   = '0;
          hit_d    = 1'b0;
          mtag_d   = '0;
          full_d   = 1'b0;
          rd_addr  = '0;
          unique case (mode)
            lpm_pkg::MODE_INSERT: begin
              insert_d = 1'b1;
              remain_d = plen_sat;
              rd_en    = 1'b1;
              state_d  = ST_WALK;
            end
            lpm_pkg::MODE_LOOKUP: begin
              insert_d = 1'b0;
              remain_d = RemW'(ADDRESS_BITS);
              if (root_clr_q) begin
                state_d = ST_OUT;
              end else begin
                rd_en   = 1'b1;
                state_d = ST_WALK;
              end
            end
            lpm_pkg::MODE_CLEAR: begin
              next_free_d = FreeW'(1);
              cnt_d       = '0;
              root_clr_d  = 1'b1;
              state_d     = ST_OUT;
            end
            default: begin
              state_d = ST_OUT;
            end
          endcase
        end
      end

      ST_WALK: begin
        if (!insert_q) begin
          if (cur.has) begin
            found_d = 1'b1;
            best_d  = cur.tag;
          end
          if (remain_q == '0 || child == '0) begin
            hit_d   = found_d;
            mtag_d  = lpm_pkg::TagW'(best_d);
            state_d = ST_OUT;
          end else begin
            rd_en    = 1'b1;
            node_d   = child;
            remain_d = remain_q - 1'b1;
            addr_d   = addr_q << 1;
          end
        end else if (remain_q == '0) begin
          wr_en       = 1'b1;
          wr_word.has = 1'b1;
          wr_word.tag = tag_q;
          cnt_d       = cnt_inc;
          root_clr_d  = 1'b0;
          state_d     = ST_OUT;
        end else if (child != '0) begin
          rd_en    = 1'b1;
          node_d   = child;
          remain_d = remain_q - 1'b1;
          addr_d   = addr_q << 1;
        end else if (pool_empty) begin
          full_d  = 1'b1;
          state_d = ST_OUT;
        end else begin
          // Hook a new node under the current one; the rest of the path is new.
          wr_en = 1'b1;
          if (addr_bit) begin
            wr_word.right = new_idx;
          end else begin
            wr_word.left = new_idx;
          end
          root_clr_d  = 1'b0;
          node_d      = new_idx;
          next_free_d = next_free_q + 1'b1;
          remain_d    = remain_q - 1'b1;
          addr_d      = addr_q << 1;
          state_d     = ST_FRESH;
        end
      end

      ST_FRESH: begin
        // The current node was just handed out, so its word is written whole here.
        wr_en   = 1'b1;
        wr_word = '0;
        if (remain_q == '0) begin
          wr_word.has = 1'b1;
          wr_word.tag = tag_q;
          cnt_d       = cnt_inc;
          state_d     = ST_OUT;
        end else if (pool_empty) begin
          full_d  = 1'b1;
          state_d = ST_OUT;
        end else begin
          if (addr_bit) begin
            wr_word.right = new_idx;
          end else begin
            wr_word.left = new_idx;
          end
          node_d      = new_idx;
          next_free_d = next_free_q + 1'b1;
          remain_d    = remain_q - 1'b1;
          addr_d      = addr_q << 1;
        end
      end

      ST_OUT: begin
        if (m_axis_tready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      next_free_q <= FreeW'(1);
      cnt_q       <= '0;
      root_clr_q  <= 1'b1;
      insert_q    <= 1'b0;
      found_q     <= 1'b0;
      hit_q       <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      next_free_q <= next_free_d;
      cnt_q       <= cnt_d;
      root_clr_q  <= root_clr_d;
      insert_q    <= insert_d;
      found_q     <= found_d;
      hit_q       <= hit_d;
      full_q      <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q   <= addr_d;
    remain_q <= remain_d;
    node_q   <= node_d;
    tag_q    <= tag_d;
    best_q   <= best_d;
    mtag_q   <= mtag_d;
  end

  // The bump pointer stays inside the pool.
  a_free_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q >= FreeW'(1) && next_free_q <= FreeW'(NODE_COUNT))
    else $error("free node pointer out of range");

  // Only the walk states touch the node memory for writing.
  a_write_state : assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == ST_WALK || state_q == ST_FRESH))
    else $error("node memory written outside a walk");

  // A freshly allocated node is always the newest one handed out.
  a_fresh_node : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FRESH |-> {1'b0, node_q} == next_free_q - 1'b1)
    else $error("fresh node is not the last allocated one");

  // The prefix count only falls through a clear.
  a_count_mono : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_hs && mode == lpm_pkg::MODE_CLEAR) |=> cnt_q >= $past(cnt_q))
    else $error("prefix count fell without a clear");

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking testbench for ipv4_longest_prefix_match: streams insert, lookup and
// clear commands and checks every result word against a trie kept in the bench.
// Depends on lpm_pkg and the RTL of the block.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NodeTotal  = lpm_pkg::NodeCountDef;
  localparam int          CycleLimit = 400000;

  typedef struct packed {
    logic                       hit;
    logic [lpm_pkg::TagW-1:0]   match_tag;
    logic                       table_full;
    logic [lpm_pkg::CountW-1:0] stored_prefixes;
  } lpm_result_t;

  // Shadow of the trie: predicts each result word and checks the words in order.
  class route_table_shadow;
    int unsigned              left_link[NodeTotal];
    int unsigned              right_link[NodeTotal];
    bit                       tag_valid[NodeTotal];
    bit [lpm_pkg::TagW-1:0]   tag_value[NodeTotal];
    int unsigned              next_free;
    bit [lpm_pkg::CountW-1:0] prefix_count;
    bit                       root_empty;
    lpm_result_t              expected_results[$];
    int                       error_count;

    function new();
      next_free    = 1;
      prefix_count = '0;
      root_empty   = 1'b1;
      error_count  = 0;
    endfunction

    function void blank_node(int unsigned n);
      left_link[n]  = 0;
      right_link[n] = 0;
      tag_valid[n]  = 1'b0;
      tag_value[n]  = '0;
    endfunction

    // Returns 1 when the node pool ran dry during the walk.
    function bit insert_prefix(bit [lpm_pkg::AddrW-1:0] addr, int unsigned plen,
                               bit [lpm_pkg::TagW-1:0] tag);
      int unsigned node;
      int unsigned child;
      int          pos;
      int          stop;
      node = 0;
      if (plen > lpm_pkg::AddrW) plen = lpm_pkg::AddrW;
      if (root_empty) begin
        blank_node(0);
        root_empty = 1'b0;
      end
      stop = lpm_pkg::AddrW - plen;
      for (pos = lpm_pkg::AddrW - 1; pos >= stop; pos--) begin
        child = addr[pos] ? right_link[node] : left_link[node];
        if (child == 0) begin
          if (next_free >= NodeTotal) return 1'b1;
          child = next_free;
          next_free++;
          blank_node(child);
          if (addr[pos]) right_link[node] = child;
          else left_link[node] = child;
        end
        node = child;
      end
      tag_valid[node] = 1'b1;
      tag_value[node] = tag;
      if (prefix_count != lpm_pkg::CountMax) prefix_count++;
      return 1'b0;
    endfunction

    function void lookup_address(input bit [lpm_pkg::AddrW-1:0] addr, output bit found,
                                 output bit [lpm_pkg::TagW-1:0] best);
      int unsigned node;
      int          pos;
      found = 1'b0;
      best  = '0;
      if (root_empty) return;
      node = 0;
      for (pos = lpm_pkg::AddrW - 1; pos >= -1; pos--) begin
        if (tag_valid[node]) begin
          found = 1'b1;
          best  = tag_value[node];
        end
        if (pos < 0) break;
        node = addr[pos] ? right_link[node] : left_link[node];
        if (node == 0) break;
      end
    endfunction

    function void note_command(lpm_pkg::mode_e mode, bit [lpm_pkg::AddrW-1:0] addr,
                               bit [lpm_pkg::PlenW-1:0] plen,
                               bit [lpm_pkg::TagW-1:0] tag);
      lpm_result_t            res;
      bit                     found;
      bit [lpm_pkg::TagW-1:0] best;
      res = '0;
      case (mode)
        lpm_pkg::MODE_INSERT: begin
          res.table_full = insert_prefix(addr, plen, tag);
        end
        lpm_pkg::MODE_LOOKUP: begin
          lookup_address(addr, found, best);
          res.hit       = found;
          res.match_tag = best;
        end
        lpm_pkg::MODE_CLEAR: begin
          next_free    = 1;
          prefix_count = '0;
          root_empty   = 1'b1;
        end
        default: begin
        end
      endcase
      res.stored_prefixes = prefix_count;
      expected_results.push_back(res);
    endfunction

    function void check_result(logic [lpm_pkg::OutDataW-1:0] word);
      lpm_result_t exp_res;
      if (expected_results.size() == 0) begin
        $display("%0t: result word %h arrived with no command pending", $time, word);
        error_count++;
        return;
      end
      exp_res = expected_results.pop_front();
      if (word[0] !== exp_res.hit) begin
        $display("%0t: hit mismatch, expected %h, actual %h", $time, exp_res.hit, word[0]);
        error_count++;
      end
      if (word[16:1] !== exp_res.match_tag) begin
        $display("%0t: match_tag mismatch, expected %h, actual %h", $time,
                 exp_res.match_tag, word[16:1]);
        error_count++;
      end
      if (word[17] !== exp_res.table_full) begin
        $display("%0t: table_full mismatch, expected %h, actual %h", $time,
                 exp_res.table_full, word[17]);
        error_count++;
      end
      if (word[37:18] !== exp_res.stored_prefixes) begin
        $display("%0t: stored_prefixes mismatch, expected %h, actual %h", $time,
                 exp_res.stored_prefixes, word[37:18]);
        error_count++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         s_axis_tvalid_i;
  logic                         s_axis_tready_o;
  // address [31:0], prefix_len [37:32], info_tag [53:38], zero [55:54]
  logic [lpm_pkg::InDataW-1:0]  s_axis_tdata_i;
  // mode [1:0]
  logic [lpm_pkg::ModeW-1:0]    s_axis_tuser_i;
  logic                         m_axis_tvalid_o;
  logic                         m_axis_tready_i;
  // hit [0], match_tag [16:1], table_full [17], stored_prefixes [37:18], zero [39:38]
  logic [lpm_pkg::OutDataW-1:0] m_axis_tdata_o;

  route_table_shadow shadow = new();

  int  cycle_count    = 0;
  int  results_seen   = 0;
  bit  sender_quiet   = 1'b0;
  bit  receiver_quiet = 1'b0;
  bit  long_hold_done = 1'b0;
  bit [lpm_pkg::AddrW-1:0] route_bases[$];

  ipv4_longest_prefix_match u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("[ipv4_longest_prefix_match] ERROR");
      $finish;
    end
  end

  // Results are checked before the command of the same edge is noted, since a
  // result always belongs to an earlier command.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        shadow.check_result(m_axis_tdata_o);
        results_seen++;
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        shadow.note_command(lpm_pkg::mode_e'(s_axis_tuser_i), s_axis_tdata_i[31:0],
                            s_axis_tdata_i[37:32], s_axis_tdata_i[53:38]);
      end
    end
  end

  // Receiver: random stalls per word, quiet stretches, and one long hold-off
  // that backs the block up into its input.
  initial begin
    int hold;
    m_axis_tready_i = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (results_seen >= 300 && !long_hold_done) begin
        hold = 400;
        long_hold_done = 1'b1;
      end else begin
        hold = receiver_quiet ? 0 : $urandom_range(0, 14);
      end
      if ($urandom_range(0, 39) == 0) receiver_quiet = !receiver_quiet;
      if (hold > 0) begin
        m_axis_tready_i = 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      m_axis_tready_i = 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      @(negedge clk_i);
    end
  end

  // Starts at the falling edge and returns at the falling edge after acceptance.
  task automatic send_command(lpm_pkg::mode_e mode, bit [lpm_pkg::AddrW-1:0] addr,
                              bit [lpm_pkg::PlenW-1:0] plen,
                              bit [lpm_pkg::TagW-1:0] tag);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 14);
    if ($urandom_range(0, 39) == 0) sender_quiet = !sender_quiet;
    if (gap > 0) begin
      s_axis_tvalid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata_i  = {2'b00, tag, plen, addr};
    s_axis_tuser_i  = mode;
    s_axis_tvalid_i = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    @(negedge clk_i);
  endtask

  // An address that shares a random number of leading bits with a known route.
  function automatic bit [lpm_pkg::AddrW-1:0] near_route();
    bit [lpm_pkg::AddrW-1:0] base;
    int unsigned             keep;
    if (route_bases.size() == 0) return $urandom();
    base = route_bases[$urandom_range(0, route_bases.size() - 1)];
    keep = $urandom_range(0, lpm_pkg::AddrW);
    return base ^ ($urandom() & (32'hffff_ffff >> keep));
  endfunction

  initial begin
    int                      choice;
    bit                      fill_phase;
    bit [lpm_pkg::AddrW-1:0] addr;
    bit [lpm_pkg::PlenW-1:0] plen;
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = lpm_pkg::MODE_NONE;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, unused code, default route, extremes and saturation.
    send_command(lpm_pkg::MODE_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
    send_command(lpm_pkg::MODE_NONE,   32'hffff_ffff, 6'd63, 16'hffff);
    send_command(lpm_pkg::MODE_CLEAR,  32'h0000_0000, 6'd0, 16'h0000);
    send_command(lpm_pkg::MODE_INSERT, 32'h0000_0000, 6'd0, 16'h1234);
    send_command(lpm_pkg::MODE_LOOKUP, 32'hffff_ffff, 6'd0, 16'h0000);
    send_command(lpm_pkg::MODE_INSERT, 32'hffff_ffff, 6'd32, 16'hffff);
    send_command(lpm_pkg::MODE_LOOKUP, 32'hffff_ffff, 6'd0, 16'h0000);
    send_command(lpm_pkg::MODE_INSERT, 32'h0000_0000, 6'd63, 16'h0000);
    send_command(lpm_pkg::MODE_LOOKUP, 32'h0000_0000, 6'd0, 16'h0000);
    send_command(lpm_pkg::MODE_INSERT, 32'hc0a8_0000, 6'd16, 16'h00aa);
    send_command(lpm_pkg::MODE_LOOKUP, 32'hc0a8_0101, 6'd0, 16'h0000);
    send_command(lpm_pkg::MODE_LOOKUP, 32'hc0a9_0000, 6'd0, 16'h0000);
    send_command(lpm_pkg::MODE_INSERT, 32'hc0a8_0100, 6'd24, 16'h00bb);
    send_command(lpm_pkg::MODE_LOOKUP, 32'hc0a8_01ff, 6'd0, 16'h0000);
    // Overwriting a tag still raises the count.
    send_command(lpm_pkg::MODE_INSERT, 32'hc0a8_0000, 6'd16, 16'h5555);
    send_command(lpm_pkg::MODE_LOOKUP, 32'hc0a8_0201, 6'd0, 16'h0000);
    send_command(lpm_pkg::MODE_INSERT, 32'h8000_0000, 6'd33, 16'h00ff);
    send_command(lpm_pkg::MODE_NONE,   32'h0000_0000, 6'd0, 16'h0000);
    send_command(lpm_pkg::MODE_CLEAR,  32'hffff_ffff, 6'd63, 16'hffff);
    send_command(lpm_pkg::MODE_LOOKUP, 32'hffff_ffff, 6'd0, 16'h0000);
    send_command(lpm_pkg::MODE_INSERT, 32'haaaa_aaaa, 6'd1, 16'h0007);
    send_command(lpm_pkg::MODE_LOOKUP, 32'h5555_5555, 6'd0, 16'h0000);
    send_command(lpm_pkg::MODE_LOOKUP, 32'haaaa_aaaa, 6'd0, 16'h0000);
    send_command(lpm_pkg::MODE_CLEAR,  32'h0000_0000, 6'd0, 16'h0000);

    // Random: epochs that start from an empty table; odd epochs are insert-heavy
    // with long prefixes so that the node pool runs out.
    for (int epoch = 0; epoch < 5; epoch++) begin
      fill_phase = epoch[0];
      route_bases.delete();
      send_command(lpm_pkg::MODE_CLEAR, $urandom(), lpm_pkg::PlenW'($urandom()),
                   lpm_pkg::TagW'($urandom()));
      for (int n = 0; n < 280; n++) begin
        choice = $urandom_range(0, 299);
        if (choice == 0) begin
          send_command(lpm_pkg::MODE_CLEAR, $urandom(), lpm_pkg::PlenW'($urandom()),
                       lpm_pkg::TagW'($urandom()));
        end else if (choice < 4) begin
          send_command(lpm_pkg::MODE_NONE, $urandom(), lpm_pkg::PlenW'($urandom()),
                       lpm_pkg::TagW'($urandom()));
        end else if (choice < (fill_phase ? 214 : 124)) begin
          addr = ($urandom_range(0, 1) == 0) ? near_route() : $urandom();
          if ($urandom_range(0, 15) == 0) begin
            plen = lpm_pkg::PlenW'($urandom_range(33, 63));
          end else if (fill_phase || $urandom_range(0, 1) == 0) begin
            plen = lpm_pkg::PlenW'($urandom_range(24, 32));
          end else begin
            plen = lpm_pkg::PlenW'($urandom_range(0, 32));
          end
          route_bases.push_back(addr);
          if (route_bases.size() > 64) void'(route_bases.pop_front());
          send_command(lpm_pkg::MODE_INSERT, addr, plen, lpm_pkg::TagW'($urandom()));
        end else begin
          addr = ($urandom_range(0, 9) < 7) ? near_route() : $urandom();
          send_command(lpm_pkg::MODE_LOOKUP, addr, lpm_pkg::PlenW'($urandom()),
                       lpm_pkg::TagW'($urandom()));
        end
      end
    end
    s_axis_tvalid_i = 1'b0;

    while (shadow.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (shadow.error_count == 0 && shadow.pending() == 0) begin
      $display("[ipv4_longest_prefix_match] OK");
    end else begin
      $display("[ipv4_longest_prefix_match] ERROR");
    end
    $finish;
  end

endmodule
